@@ rtl/hrbi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbi_pkg
// Shared types and constants for the beat interval heart rate block.
// ----------------------------------------------------------------------------
package hrbi_pkg;

    // Serial divider operand widths: 60000 needs 16 bits, 2000 ms needs 11.
    localparam int DIV_N_W = 16;
    localparam int DIV_D_W = 11;
    localparam int DIV_C_W = $clog2(DIV_N_W + 1);

    localparam int TIME_W  = 32;
    localparam int IR_W    = 18;
    localparam int TMO_W   = 16;
    localparam int RATE_W  = 8;

    localparam logic [TIME_W-1:0]  MIN_INTERVAL_MS = 32'd250;
    localparam logic [TIME_W-1:0]  MAX_INTERVAL_MS = 32'd2000;
    localparam logic [DIV_N_W-1:0] MS_PER_MINUTE   = 16'd60000;
    localparam logic [DIV_N_W-1:0] MIN_BPM         = 16'd20;
    localparam logic [DIV_N_W-1:0] MAX_BPM         = 16'd240;

    localparam logic [IR_W-1:0]  FINGER_THRESHOLD_RST = 18'd50000;
    localparam logic [TMO_W-1:0] LOST_TIMEOUT_RST     = 16'd3000;

    // Configuration register indexes.
    localparam logic CFG_FINGER_THRESHOLD = 1'b0;
    localparam logic CFG_LOST_TIMEOUT     = 1'b1;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/heart_rate_from_beat_intervals_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_from_beat_intervals_top
// Averaged heart rate from beat-to-beat intervals with finger detection.
// ----------------------------------------------------------------------------
//  Channel      Direction  Contents
//  s_axis       in         tdata: time_ms, ir_sample; tuser: beat_seen
//  m_axis       out        tdata: heart_rate; tuser: finger_present
//  cfg          in         index 0 finger_threshold, index 1 lost_timeout_ms
//
//  A sample without a valid beat interval goes from ST_EVAL through ST_OUT
//  to the result. A sample that yields a new rate takes two 16-step passes
//  of the shared bit-serial divider (rate, then mean), with a sum over the
//  valid ring entries between them. One sample is in work at a time; the
//  next is taken while the previous result waits at m_axis.
//  Reset is asynchronous and clears control state and average, not the ring.
// ----------------------------------------------------------------------------
module heart_rate_from_beat_intervals_top
    import hrbi_pkg::*;
#(
    parameter int RING_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [31:0] time_ms, [49:32] ir_sample
    input  logic        s_axis_tuser,   // [0] beat_seen
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] heart_rate
    output logic        m_axis_tuser,   // [0] finger_present
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [17:0] cfg_wdata
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = RATE_W + CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_BPM    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_AVG_GO = 3'd4;
    localparam logic [2:0] ST_AVG    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]        state_reg;
    logic [IR_W-1:0]   threshold_reg;
    logic [TMO_W-1:0]  timeout_reg;

    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] interval_reg;
    logic              finger_reg;
    logic              beat_reg;

    logic [TIME_W-1:0] last_beat_reg;
    logic              beat_valid_reg;
    logic [RATE_W-1:0] ring_reg [RING_DEPTH];
    logic [IDX_W-1:0]  ring_idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RATE_W-1:0] average_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  sum_cnt_reg;

    logic              m_valid_reg;
    logic [RATE_W-1:0] m_rate_reg;
    logic              m_finger_reg;

    logic              lost;
    logic              in_range;
    logic              bpm_ok;
    logic              out_free;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign lost     = !beat_valid_reg || (interval_reg >= TIME_W'(timeout_reg));
    assign in_range = (interval_reg >= MIN_INTERVAL_MS) && (interval_reg <= MAX_INTERVAL_MS);
    assign bpm_ok   = (div_rsp.quotient >= MIN_BPM) && (div_rsp.quotient <= MAX_BPM);
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // One divider serves the rate and, later, the mean over the ring.
    always_comb
    begin
        div_req.start    = ((state_reg == ST_EVAL) && finger_reg && beat_reg
                            && beat_valid_reg && in_range)
                           || (state_reg == ST_AVG_GO);
        div_req.dividend = (state_reg == ST_AVG_GO) ? DIV_N_W'(sum_reg) : MS_PER_MINUTE;
        div_req.divisor  = (state_reg == ST_AVG_GO) ? DIV_D_W'(count_reg)
                                                     : interval_reg[DIV_D_W-1:0];
    end

    hrbi_sdiv u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= FINGER_THRESHOLD_RST;
            timeout_reg   <= LOST_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FINGER_THRESHOLD: threshold_reg <= cfg_wdata;
                CFG_LOST_TIMEOUT:     timeout_reg   <= cfg_wdata[TMO_W-1:0];
                default:              threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_beat_reg  <= '0;
            beat_valid_reg <= 1'b0;
            ring_idx_reg   <= '0;
            count_reg      <= '0;
            average_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    state_reg <= ST_OUT;
                    if (!finger_reg)
                    begin
                        if (lost)
                        begin
                            average_reg  <= '0;
                            count_reg    <= '0;
                            ring_idx_reg <= '0;
                        end
                    end
                    else if (beat_reg)
                    begin
                        last_beat_reg  <= now_reg;
                        beat_valid_reg <= 1'b1;
                        if (beat_valid_reg && in_range)
                        begin
                            state_reg <= ST_BPM;
                        end
                    end
                end
                ST_BPM:
                begin
                    if (div_rsp.done)
                    begin
                        if (bpm_ok)
                        begin
                            ring_idx_reg <= (ring_idx_reg == IDX_W'(RING_DEPTH - 1))
                                            ? '0 : ring_idx_reg + 1'b1;
                            if (count_reg != CNT_W'(RING_DEPTH))
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= ST_SUM;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SUM:
                begin
                    if (sum_cnt_reg + 1'b1 == count_reg)
                    begin
                        state_reg <= ST_AVG_GO;
                    end
                end
                ST_AVG_GO:
                begin
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    if (div_rsp.done)
                    begin
                        average_reg <= div_rsp.quotient[RATE_W-1:0];
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && s_axis_tvalid)
        begin
            now_reg      <= s_axis_tdata[TIME_W-1:0];
            interval_reg <= s_axis_tdata[TIME_W-1:0] - last_beat_reg;
            finger_reg   <= s_axis_tdata[TIME_W+IR_W-1:TIME_W] >= threshold_reg;
            beat_reg     <= s_axis_tuser;
        end
        if ((state_reg == ST_BPM) && div_rsp.done && bpm_ok)
        begin
            ring_reg[ring_idx_reg] <= div_rsp.quotient[RATE_W-1:0];
            sum_reg                <= '0;
            sum_cnt_reg            <= '0;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg     <= sum_reg + SUM_W'(ring_reg[sum_cnt_reg[IDX_W-1:0]]);
            sum_cnt_reg <= sum_cnt_reg + 1'b1;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_rate_reg   <= average_reg;
            m_finger_reg <= finger_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_rate_reg;
    assign m_axis_tuser  = m_finger_reg;

    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= MAX_BPM[RATE_W-1:0]))
        else $error("heart rate above the upper bpm limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("valid entry count exceeds ring depth");

    a_bpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BPM) && div_rsp.done) |-> bpm_ok)
        else $error("rate from an accepted interval out of bpm range");

    a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (count_reg != '0))
        else $error("ring summed with no valid entries");

endmodule

@@ rtl/hrbi_sdiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbi_sdiv
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrbi_sdiv
    import hrbi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic               done_reg;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    // The dividend shifts out at the top while quotient bits shift in below.
    assign trial = {rem_reg, num_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= DIV_C_W'(DIV_N_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DIV_C_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule
